// ===== design/bf_pkg.sv =====
package bf_pkg;

	localparam int DEF_MAX_FILTER_BITS = 65536;
	localparam int MAX_HASH_ROUNDS     = 32;

	localparam int BIT_COUNT_W   = 17;
	localparam int HASH_ROUNDS_W = 6;
	localparam int ROUND_W       = 7;
	localparam int CFG_INDEX_W   = 8;
	localparam int CFG_DATA_W    = 17;

	localparam logic [CFG_INDEX_W-1:0] REG_BIT_COUNT   = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_HASH_ROUNDS = 8'd1;

	localparam logic [BIT_COUNT_W-1:0]   BIT_COUNT_RST   = 17'd65536;
	localparam logic [HASH_ROUNDS_W-1:0] HASH_ROUNDS_RST = 6'd7;

	localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;

	localparam logic FUNC_CHECK = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIG1,
		ST_DIG2,
		ST_DIV,
		ST_RD,
		ST_UPD,
		ST_FIN
	} bf_state_t;

	typedef struct packed {
		logic clr_we;
		logic accept;
		logic dig1;
		logic dig2;
		logic div_init;
		logic div_step;
		logic rd_en;
		logic wr_en;
		logic fail;
		logic seed_inc;
		logic out_load;
	} bf_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic tens_nz;
		logic div_done;
		logic rounds_zero;
		logic seed_last;
		logic bit_set;
		logic is_check;
		logic out_free;
	} bf_stat_t;

	// xor the byte in, multiply by the FNV prime 2^40 + 0x1b3 as shifted adds
	function automatic logic [63:0] fnv_fold(input logic [63:0] h, input logic [7:0] b);
		logic [63:0] x;
		x = h ^ {56'd0, b};
		return x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8) + (x << 40);
	endfunction

endpackage

// ===== design/bloom_filter_fnv1a.sv =====
// Bloom filter with 64-bit FNV-1a hashing. Key bytes arrive one transaction each and are
// folded into the running hash when accepted with byte_present set. The transaction flagged
// key_last starts the probes, or with zero hash rounds goes straight to the result. Each seed
// folds its decimal digits into the key hash (the tens digit first from seed 10 on), reduces
// the hash modulo the filter size in the bit-serial modulo unit, then reads the filter word
// and, for an add, sets the bit. The result is then handed over, waiting while an earlier
// result is still held and stalled. A check stops at the first clear bit. After reset the
// block sweeps the filter memory clear, one 32-bit word a cycle over all MAX_FILTER_BITS/32
// words, and accepts no key data meanwhile. Configuration writes are taken at any time but
// should only be made while the block is idle.
module bloom_filter_fnv1a import bf_pkg::*; #(
	parameter int MAX_FILTER_BITS = DEF_MAX_FILTER_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   func,
	input  logic [7:0]             key_byte,
	input  logic                   byte_present,
	input  logic                   key_last,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   was_add,
	output logic                   found
);

	bf_cmd_t  cmd;
	bf_stat_t stat;

	bf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.key_last (key_last),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	bf_dp #(.MAX_FILTER_BITS(MAX_FILTER_BITS)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.func         (func),
		.key_byte     (key_byte),
		.byte_present (byte_present),
		.key_last     (key_last),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.was_add      (was_add),
		.found        (found),
		.cmd          (cmd),
		.stat         (stat)
	);

	// an add always reports found
	a_add_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && was_add |-> found)
		else $error("add result without found");

	// a result is only loaded while key data is held off
	a_load_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result loaded while accepting key data");

endmodule

// ===== design/bf_ram.sv =====
module bf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/bf_ctrl.sv =====
module bf_ctrl import bf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     key_last,
	output logic     in_stall,
	input  bf_stat_t stat,
	output bf_cmd_t  cmd
);

	bf_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_we = 1'b1;
				if (stat.clr_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (key_last) state_d = stat.rounds_zero ? ST_FIN : ST_DIG1;
				end
			end
			ST_DIG1: begin
				cmd.dig1 = 1'b1;
				if (stat.tens_nz) begin
					state_d = ST_DIG2;
				end else begin
					cmd.div_init = 1'b1;
					state_d      = ST_DIV;
				end
			end
			ST_DIG2: begin
				cmd.dig2     = 1'b1;
				cmd.div_init = 1'b1;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_done) state_d = ST_RD;
			end
			ST_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_UPD;
			end
			ST_UPD: begin
				if (stat.is_check && !stat.bit_set) begin
					cmd.fail = 1'b1;
					state_d  = ST_FIN;
				end else begin
					cmd.wr_en = !stat.is_check;
					if (stat.seed_last) begin
						state_d = ST_FIN;
					end else begin
						cmd.seed_inc = 1'b1;
						state_d      = ST_DIG1;
					end
				end
			end
			ST_FIN: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

endmodule

// ===== design/bf_dp.sv =====
module bf_dp import bf_pkg::*; #(
	parameter int MAX_FILTER_BITS = DEF_MAX_FILTER_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_INDEX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data,
	input  logic                     func,
	input  logic [7:0]               key_byte,
	input  logic                     byte_present,
	input  logic                     key_last,
	input  logic                     out_stall,
	output logic                     out_valid,
	output logic                     was_add,
	output logic                     found,
	input  bf_cmd_t                  cmd,
	output bf_stat_t                 stat
);

	localparam int DEPTH = MAX_FILTER_BITS / 32;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int IW    = (AW + 5 > BIT_COUNT_W) ? AW + 5 : BIT_COUNT_W;

	logic [BIT_COUNT_W-1:0]   bit_count_q;
	logic [HASH_ROUNDS_W-1:0] hash_rounds_q;
	logic [63:0]              hash_q;
	logic [63:0]              ph_q;
	logic [BIT_COUNT_W-1:0]   rem_q;
	logic [5:0]               cnt_q;
	logic [3:0]               tens_q, units_q;
	logic [ROUND_W-1:0]       seed_q;
	logic                     check_q, found_q;
	logic                     out_valid_q, was_add_q, out_found_q;
	logic [AW-1:0]            clr_addr_q;

	logic [BIT_COUNT_W-1:0]   nbits;
	logic [ROUND_W-1:0]       rounds;
	logic [BIT_COUNT_W:0]     trial;
	logic [BIT_COUNT_W:0]     diff;
	logic [IW-1:0]            rem_ext;
	logic [AW-1:0]            word_addr;
	logic [31:0]              rdata;
	logic [7:0]               dig1_char;

	// round down to a multiple of 32 (zero becomes 32), then saturate into the filter size; clamp the hash rounds
	always_comb begin
		nbits = {bit_count_q[BIT_COUNT_W-1:5], 5'd0};
		if (nbits == '0) nbits = BIT_COUNT_W'(32);
		if (32'(nbits) > 32'(MAX_FILTER_BITS)) nbits = BIT_COUNT_W'(MAX_FILTER_BITS);
		rounds = {1'b0, hash_rounds_q};
		if (32'(rounds) > 32'(MAX_HASH_ROUNDS)) rounds = ROUND_W'(MAX_HASH_ROUNDS);
	end

	assign trial     = {rem_q, ph_q[63]};
	assign diff      = trial - {1'b0, nbits};
	assign rem_ext   = IW'(rem_q);
	assign word_addr = rem_ext[AW+4:5];
	assign dig1_char = (tens_q != 4'd0) ? {4'h3, tens_q} : {4'h3, units_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_count_q   <= BIT_COUNT_RST;
			hash_rounds_q <= HASH_ROUNDS_RST;
			hash_q        <= FNV_BASIS;
			clr_addr_q    <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == REG_BIT_COUNT) bit_count_q <= cfg_data[BIT_COUNT_W-1:0];
			if (cfg_we && cfg_index == REG_HASH_ROUNDS) begin
				hash_rounds_q <= cfg_data[HASH_ROUNDS_W-1:0];
			end
			if (cmd.out_load) begin
				hash_q <= FNV_BASIS;
			end else if (cmd.accept && byte_present) begin
				hash_q <= fnv_fold(hash_q, key_byte);
			end
			if (cmd.clr_we) clr_addr_q <= clr_addr_q + AW'(1);
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && key_last) begin
			check_q <= (func == FUNC_CHECK);
			found_q <= 1'b1;
			tens_q  <= 4'd0;
			units_q <= 4'd0;
			seed_q  <= '0;
		end
		if (cmd.fail) found_q <= 1'b0;
		if (cmd.seed_inc) begin
			seed_q <= seed_q + ROUND_W'(1);
			if (units_q == 4'd9) begin
				units_q <= 4'd0;
				tens_q  <= tens_q + 4'd1;
			end else begin
				units_q <= units_q + 4'd1;
			end
		end
		if (cmd.dig1) begin
			ph_q <= fnv_fold(hash_q, dig1_char);
		end else if (cmd.dig2) begin
			ph_q <= fnv_fold(ph_q, {4'h3, units_q});
		end else if (cmd.div_step) begin
			ph_q <= {ph_q[62:0], 1'b0};
		end
		if (cmd.div_init) begin
			rem_q <= '0;
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= diff[BIT_COUNT_W] ? trial[BIT_COUNT_W-1:0] : diff[BIT_COUNT_W-1:0];
			cnt_q <= cnt_q + 6'd1;
		end
		if (cmd.out_load) begin
			was_add_q   <= !check_q;
			out_found_q <= found_q;
		end
	end

	bf_ram #(.WIDTH(32), .DEPTH(DEPTH), .AW(AW)) u_ram (
		.clk   (clk),
		.we    (cmd.clr_we || cmd.wr_en),
		.waddr (cmd.clr_we ? clr_addr_q : word_addr),
		.wdata (cmd.clr_we ? 32'd0 : (rdata | (32'd1 << rem_q[4:0]))),
		.re    (cmd.rd_en),
		.raddr (word_addr),
		.rdata (rdata)
	);

	always_comb begin
		stat.clr_done    = (clr_addr_q == AW'(DEPTH - 1));
		stat.tens_nz     = (tens_q != 4'd0);
		stat.div_done    = (cnt_q == 6'd63);
		stat.rounds_zero = (rounds == '0);
		stat.seed_last   = ((seed_q + ROUND_W'(1)) == rounds);
		stat.bit_set     = rdata[rem_q[4:0]];
		stat.is_check    = check_q;
		stat.out_free    = !out_valid_q || !out_stall;
	end

	assign out_valid = out_valid_q;
	assign was_add   = was_add_q;
	assign found     = out_found_q;

endmodule
